/* sv/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while reset is released
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked on every clock edge, reset included
`define ASSERT_ANY(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

/* sv/pwlcr_pkg.sv */
// shared widths, types, register indexes and helpers for the color ramp
// no dependencies; compile first
`timescale 1ns / 1ps
`default_nettype none

package pwlcr_pkg;

    localparam int ROW_W      = 10;
    localparam int RC_W       = 11;
    localparam int CH_W       = 16;
    localparam int FRAC_W     = 16;
    localparam int Y_W        = FRAC_W + 1;
    localparam int NUM_CH     = 3;
    localparam int NUM_STOPS  = 4;
    localparam int MAX_ROWS   = 1024;

    // row * 2^16 / rc stays below 2^16 for row < rc
    localparam int DIV1_STEPS = FRAC_W;
    // |y - start| * 2^16 needs up to 33 quotient bits
    localparam int DIV2_STEPS = Y_W + FRAC_W;
    localparam int T_W        = DIV2_STEPS + 1;
    localparam int DIFF_W     = CH_W + 1;
    localparam int PROD_W     = T_W + DIFF_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int HEIGHTS_W  = NUM_STOPS * CH_W;
    localparam int COLOR_W    = NUM_CH * CH_W;

    // input reg + divider 1 + y/segment/prep + divider 2 + t/mul/clamp
    localparam int PIPE_DEPTH    = 1 + DIV1_STEPS + 3 + DIV2_STEPS + 3;
    localparam int MAX_IN_FLIGHT = PIPE_DEPTH + 2;
    localparam int FLIGHT_W      = $clog2(MAX_IN_FLIGHT + 1);

    typedef logic [ROW_W-1:0]                 t_row;
    typedef logic [RC_W-1:0]                  t_rc;
    typedef logic [CH_W-1:0]                  t_chan;
    typedef logic [Y_W-1:0]                   t_y;
    typedef logic [FRAC_W-1:0]                t_q1;
    typedef logic [DIV2_STEPS-1:0]            t_x2;
    typedef logic signed [T_W-1:0]            t_t;
    typedef logic signed [DIFF_W-1:0]         t_diff;
    typedef logic signed [PROD_W-1:0]         t_prod;
    typedef logic signed [PROD_W-FRAC_W:0]    t_sum;
    typedef logic [CFG_IDX_W-1:0]             t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]            t_cfg_data;
    typedef logic [HEIGHTS_W-1:0]             t_heights;
    typedef logic [COLOR_W-1:0]               t_color;
    typedef logic [1:0]                       t_seg;
    typedef logic [FLIGHT_W-1:0]              t_flight;

    localparam t_cfg_idx REG_ROW_COUNT    = t_cfg_idx'(0);
    localparam t_cfg_idx REG_STOP_HEIGHTS = t_cfg_idx'(1);
    localparam t_cfg_idx REG_COLOR_STOP0  = t_cfg_idx'(2);
    localparam t_cfg_idx REG_COLOR_STOP1  = t_cfg_idx'(3);
    localparam t_cfg_idx REG_COLOR_STOP2  = t_cfg_idx'(4);
    localparam t_cfg_idx REG_COLOR_STOP3  = t_cfg_idx'(5);

    localparam t_rc RC_RESET = t_rc'(256);
    localparam t_rc RC_ONE   = t_rc'(1);
    localparam t_rc RC_MAX   = t_rc'(MAX_ROWS);
    localparam t_y  Y_ONE    = t_y'(2 ** FRAC_W);

    localparam t_seg SEG_LOW  = 2'd0;
    localparam t_seg SEG_MID  = 2'd1;
    localparam t_seg SEG_HIGH = 2'd2;

    // height of stop k, stop 0 in the low bits
    function automatic t_chan height_at(input t_heights h, input t_seg k);
        return h[k * CH_W +: CH_W];
    endfunction

endpackage

`default_nettype wire

/* sv/pwlcr_in_if.sv */
// row request channel of the color ramp
// depends on pwlcr_pkg
`timescale 1ns / 1ps
`default_nettype none

interface pwlcr_in_if;
    logic                valid;
    logic                ready;
    pwlcr_pkg::t_row     row_index;

    modport source (output valid, output row_index, input ready);
    modport sink   (input valid, input row_index, output ready);
endinterface

`default_nettype wire

/* sv/pwlcr_out_if.sv */
// color result channel of the color ramp
// depends on pwlcr_pkg
`timescale 1ns / 1ps
`default_nettype none

interface pwlcr_out_if;
    logic                valid;
    logic                ready;
    pwlcr_pkg::t_chan    red;
    pwlcr_pkg::t_chan    green;
    pwlcr_pkg::t_chan    blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

/* sv/piecewise_linear_color_ramp_top.sv */
// four-stop piecewise linear color ramp, one row color per transaction
// depends on pwlcr_pkg, pwlcr_in_if, pwlcr_out_if
//
// channel  dir  handshake           payload
// i_in     in   valid / ready       row_index[9:0]
// o_out    out  valid / ready       red[15:0], green[15:0], blue[15:0]
// cfg      in   i_cfg_we            i_cfg_idx[2:0], i_cfg_wdata[63:0]
//
// one transaction per cycle while no stalled output freezes the pipeline; the
// pipeline holds two unrolled restoring dividers (16 stages for y, 33 stages for t)
// synchronous reset clears the valid bits and loads register defaults
// a stalled output parks one result in a skid register, then the whole
// pipeline freezes through a registered enable, so i_in.ready has no
// combinational path from o_out.ready
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_color_ramp_top (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire [pwlcr_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire [pwlcr_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    pwlcr_in_if.sink                              i_in,
    pwlcr_out_if.source                           o_out
);

    localparam int L1 = pwlcr_pkg::DIV1_STEPS - 1;
    localparam int L2 = pwlcr_pkg::DIV2_STEPS - 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    pwlcr_pkg::t_rc       r_row_count;
    pwlcr_pkg::t_heights  r_stop_heights;
    pwlcr_pkg::t_color    r_color_stop0;
    pwlcr_pkg::t_color    r_color_stop1;
    pwlcr_pkg::t_color    r_color_stop2;
    pwlcr_pkg::t_color    r_color_stop3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= pwlcr_pkg::RC_RESET;
            r_stop_heights <= '0;
            r_color_stop0  <= '0;
            r_color_stop1  <= '0;
            r_color_stop2  <= '0;
            r_color_stop3  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pwlcr_pkg::REG_ROW_COUNT:    r_row_count    <= i_cfg_wdata[pwlcr_pkg::RC_W-1:0];
                pwlcr_pkg::REG_STOP_HEIGHTS: r_stop_heights <= i_cfg_wdata;
                pwlcr_pkg::REG_COLOR_STOP0:  r_color_stop0  <= i_cfg_wdata[pwlcr_pkg::COLOR_W-1:0];
                pwlcr_pkg::REG_COLOR_STOP1:  r_color_stop1  <= i_cfg_wdata[pwlcr_pkg::COLOR_W-1:0];
                pwlcr_pkg::REG_COLOR_STOP2:  r_color_stop2  <= i_cfg_wdata[pwlcr_pkg::COLOR_W-1:0];
                pwlcr_pkg::REG_COLOR_STOP3:  r_color_stop3  <= i_cfg_wdata[pwlcr_pkg::COLOR_W-1:0];
                default: ; // unknown index, write dropped
            endcase
        end
    end

    // effective row count: zero acts as one, large counts saturate
    pwlcr_pkg::t_rc rc_eff;
    always_comb begin
        if (r_row_count == '0) begin
            rc_eff = pwlcr_pkg::RC_ONE;
        end else if (r_row_count > pwlcr_pkg::RC_MAX) begin
            rc_eff = pwlcr_pkg::RC_MAX;
        end else begin
            rc_eff = r_row_count;
        end
    end

    // ------------------------------------------------------------------
    // pipeline enable: frozen only while the skid register is occupied
    // ------------------------------------------------------------------
    logic r_skid_valid;
    logic en;
    assign en         = !r_skid_valid;
    assign i_in.ready = en;

    // ------------------------------------------------------------------
    // stage A: input register
    // ------------------------------------------------------------------
    logic             r_a_valid;
    pwlcr_pkg::t_row  r_a_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_row <= i_in.row_index;
        end
    end

    // ------------------------------------------------------------------
    // divider 1: q = row * 2^16 / rc, restoring, one quotient bit a stage
    // ------------------------------------------------------------------
    pwlcr_pkg::t_rc  d1_rem_in   [pwlcr_pkg::DIV1_STEPS];
    pwlcr_pkg::t_q1  d1_q_in     [pwlcr_pkg::DIV1_STEPS];
    logic            d1_sat_in   [pwlcr_pkg::DIV1_STEPS];
    logic            d1_valid_in [pwlcr_pkg::DIV1_STEPS];

    pwlcr_pkg::t_rc  r_d1_rem    [pwlcr_pkg::DIV1_STEPS];
    pwlcr_pkg::t_q1  r_d1_q      [pwlcr_pkg::DIV1_STEPS];
    logic            r_d1_sat    [pwlcr_pkg::DIV1_STEPS];
    logic            r_d1_valid  [pwlcr_pkg::DIV1_STEPS];

    // the remainder starts at the row itself; rows at or past the count saturate
    assign d1_rem_in[0]   = pwlcr_pkg::t_rc'(r_a_row);
    assign d1_q_in[0]     = '0;
    assign d1_sat_in[0]   = pwlcr_pkg::t_rc'(r_a_row) >= rc_eff;
    assign d1_valid_in[0] = r_a_valid;

    for (genvar k = 0; k < pwlcr_pkg::DIV1_STEPS; k++) begin : g_div1
        logic [pwlcr_pkg::RC_W:0] rem_sh;
        logic                     ge;
        pwlcr_pkg::t_rc           n_rem;
        pwlcr_pkg::t_q1           n_q;

        assign rem_sh = {d1_rem_in[k], 1'b0};
        assign ge     = rem_sh >= {1'b0, rc_eff};
        assign n_rem  = ge ? pwlcr_pkg::t_rc'(rem_sh - {1'b0, rc_eff})
                           : rem_sh[pwlcr_pkg::RC_W-1:0];
        assign n_q    = pwlcr_pkg::t_q1'({d1_q_in[k], ge});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d1_valid[k] <= 1'b0;
            end else if (en) begin
                r_d1_valid[k] <= d1_valid_in[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_d1_rem[k] <= n_rem;
                r_d1_q[k]   <= n_q;
                r_d1_sat[k] <= d1_sat_in[k];
            end
        end

        if (k < L1) begin : g_link
            assign d1_rem_in[k+1]   = r_d1_rem[k];
            assign d1_q_in[k+1]     = r_d1_q[k];
            assign d1_sat_in[k+1]   = r_d1_sat[k];
            assign d1_valid_in[k+1] = r_d1_valid[k];
        end
    end

    // ------------------------------------------------------------------
    // stage Y: height y = 1 - row/rc in Q1.16
    // ------------------------------------------------------------------
    logic           r_y_valid;
    pwlcr_pkg::t_y  r_y;
    pwlcr_pkg::t_y  n_y;

    assign n_y = r_d1_sat[L1] ? '0
                              : pwlcr_pkg::Y_ONE - pwlcr_pkg::t_y'(r_d1_q[L1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_valid <= 1'b0;
        end else if (en) begin
            r_y_valid <= r_d1_valid[L1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_y <= n_y;
        end
    end

    // ------------------------------------------------------------------
    // stage S: segment choice and its bounding heights
    // ------------------------------------------------------------------
    logic              r_s_valid;
    pwlcr_pkg::t_y     r_s_y;
    pwlcr_pkg::t_seg   r_s_seg;
    pwlcr_pkg::t_chan  r_s_from;
    pwlcr_pkg::t_chan  r_s_to;
    pwlcr_pkg::t_seg   n_s_seg;

    always_comb begin
        if (r_y < pwlcr_pkg::t_y'(pwlcr_pkg::height_at(r_stop_heights, pwlcr_pkg::SEG_MID))) begin
            n_s_seg = pwlcr_pkg::SEG_LOW;
        end else if (r_y < pwlcr_pkg::t_y'(
                         pwlcr_pkg::height_at(r_stop_heights, pwlcr_pkg::SEG_HIGH))) begin
            n_s_seg = pwlcr_pkg::SEG_MID;
        end else begin
            n_s_seg = pwlcr_pkg::SEG_HIGH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (en) begin
            r_s_valid <= r_y_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s_y    <= r_y;
            r_s_seg  <= n_s_seg;
            r_s_from <= pwlcr_pkg::height_at(r_stop_heights, n_s_seg);
            r_s_to   <= pwlcr_pkg::height_at(r_stop_heights,
                                             pwlcr_pkg::t_seg'(n_s_seg + 2'd1));
        end
    end

    // ------------------------------------------------------------------
    // stage P: sign-magnitude form of (y - start) / (end - start)
    // ------------------------------------------------------------------
    logic signed [pwlcr_pkg::CH_W:0]  den;
    logic signed [pwlcr_pkg::Y_W:0]   num;
    logic signed [pwlcr_pkg::Y_W:0]   num_f;
    logic signed [pwlcr_pkg::Y_W:0]   num_abs;
    logic signed [pwlcr_pkg::CH_W:0]  den_abs;
    logic                             den_neg;
    logic                             num_neg;

    logic              r_p_valid;
    pwlcr_pkg::t_y     r_p_mag;
    pwlcr_pkg::t_chan  r_p_dmag;
    logic              r_p_neg;
    logic              r_p_zero;
    pwlcr_pkg::t_seg   r_p_seg;

    always_comb begin
        den     = signed'({1'b0, r_s_to}) - signed'({1'b0, r_s_from});
        num     = signed'({1'b0, r_s_y}) - signed'({2'b00, r_s_from});
        den_neg = den[pwlcr_pkg::CH_W];
        // a falling segment flips both signs so the divisor is positive
        num_f   = den_neg ? -num : num;
        den_abs = den_neg ? -den : den;
        num_neg = num_f[pwlcr_pkg::Y_W];
        num_abs = num_neg ? -num_f : num_f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (en) begin
            r_p_valid <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_mag  <= num_abs[pwlcr_pkg::Y_W-1:0];
            r_p_dmag <= den_abs[pwlcr_pkg::CH_W-1:0];
            r_p_neg  <= num_neg;
            r_p_zero <= (den == '0);
            r_p_seg  <= r_s_seg;
        end
    end

    // ------------------------------------------------------------------
    // divider 2: |num| * 2^16 / |den|, restoring; dividend bits shift out
    // of x at the top while quotient bits shift in at the bottom
    // ------------------------------------------------------------------
    pwlcr_pkg::t_chan  d2_rem_in   [pwlcr_pkg::DIV2_STEPS];
    pwlcr_pkg::t_x2    d2_x_in     [pwlcr_pkg::DIV2_STEPS];
    pwlcr_pkg::t_chan  d2_dmag_in  [pwlcr_pkg::DIV2_STEPS];
    logic              d2_neg_in   [pwlcr_pkg::DIV2_STEPS];
    logic              d2_zero_in  [pwlcr_pkg::DIV2_STEPS];
    pwlcr_pkg::t_seg   d2_seg_in   [pwlcr_pkg::DIV2_STEPS];
    logic              d2_valid_in [pwlcr_pkg::DIV2_STEPS];

    pwlcr_pkg::t_chan  r_d2_rem    [pwlcr_pkg::DIV2_STEPS];
    pwlcr_pkg::t_x2    r_d2_x      [pwlcr_pkg::DIV2_STEPS];
    pwlcr_pkg::t_chan  r_d2_dmag   [pwlcr_pkg::DIV2_STEPS];
    logic              r_d2_neg    [pwlcr_pkg::DIV2_STEPS];
    logic              r_d2_zero   [pwlcr_pkg::DIV2_STEPS];
    pwlcr_pkg::t_seg   r_d2_seg    [pwlcr_pkg::DIV2_STEPS];
    logic              r_d2_valid  [pwlcr_pkg::DIV2_STEPS];

    assign d2_rem_in[0]   = '0;
    assign d2_x_in[0]     = pwlcr_pkg::t_x2'({r_p_mag, {pwlcr_pkg::FRAC_W{1'b0}}});
    assign d2_dmag_in[0]  = r_p_dmag;
    assign d2_neg_in[0]   = r_p_neg;
    assign d2_zero_in[0]  = r_p_zero;
    assign d2_seg_in[0]   = r_p_seg;
    assign d2_valid_in[0] = r_p_valid;

    for (genvar k = 0; k < pwlcr_pkg::DIV2_STEPS; k++) begin : g_div2
        logic [pwlcr_pkg::CH_W:0] rem_sh;
        logic                     ge;
        pwlcr_pkg::t_chan         n_rem;
        pwlcr_pkg::t_x2           n_x;

        assign rem_sh = {d2_rem_in[k], d2_x_in[k][L2]};
        assign ge     = rem_sh >= {1'b0, d2_dmag_in[k]};
        assign n_rem  = ge ? pwlcr_pkg::t_chan'(rem_sh - {1'b0, d2_dmag_in[k]})
                           : rem_sh[pwlcr_pkg::CH_W-1:0];
        assign n_x    = pwlcr_pkg::t_x2'({d2_x_in[k], ge});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d2_valid[k] <= 1'b0;
            end else if (en) begin
                r_d2_valid[k] <= d2_valid_in[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_d2_rem[k]  <= n_rem;
                r_d2_x[k]    <= n_x;
                r_d2_dmag[k] <= d2_dmag_in[k];
                r_d2_neg[k]  <= d2_neg_in[k];
                r_d2_zero[k] <= d2_zero_in[k];
                r_d2_seg[k]  <= d2_seg_in[k];
            end
        end

        if (k < L2) begin : g_link
            assign d2_rem_in[k+1]   = r_d2_rem[k];
            assign d2_x_in[k+1]     = r_d2_x[k];
            assign d2_dmag_in[k+1]  = r_d2_dmag[k];
            assign d2_neg_in[k+1]   = r_d2_neg[k];
            assign d2_zero_in[k+1]  = r_d2_zero[k];
            assign d2_seg_in[k+1]   = r_d2_seg[k];
            assign d2_valid_in[k+1] = r_d2_valid[k];
        end
    end

    // ------------------------------------------------------------------
    // stage T: signed t with floor rounding, stop colors and deltas
    // ------------------------------------------------------------------
    pwlcr_pkg::t_t     q_ext;
    pwlcr_pkg::t_t     q_up;
    pwlcr_pkg::t_t     n_t;
    pwlcr_pkg::t_color col_a;
    pwlcr_pkg::t_color col_b;

    logic              r_t_valid;
    pwlcr_pkg::t_t     r_t_t;
    pwlcr_pkg::t_chan  r_t_a    [pwlcr_pkg::NUM_CH];
    pwlcr_pkg::t_diff  r_t_diff [pwlcr_pkg::NUM_CH];

    always_comb begin
        q_ext = pwlcr_pkg::t_t'(r_d2_x[L2]);
        // negative quotient rounds toward minus infinity
        q_up  = q_ext + pwlcr_pkg::t_t'(r_d2_rem[L2] != '0);
        if (r_d2_zero[L2]) begin
            n_t = '0;
        end else if (r_d2_neg[L2]) begin
            n_t = -q_up;
        end else begin
            n_t = q_ext;
        end
    end

    always_comb begin
        case (r_d2_seg[L2])
            pwlcr_pkg::SEG_LOW: begin
                col_a = r_color_stop0;
                col_b = r_color_stop1;
            end
            pwlcr_pkg::SEG_MID: begin
                col_a = r_color_stop1;
                col_b = r_color_stop2;
            end
            default: begin
                col_a = r_color_stop2;
                col_b = r_color_stop3;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
        end else if (en) begin
            r_t_valid <= r_d2_valid[L2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t_t <= n_t;
            for (int ch = 0; ch < pwlcr_pkg::NUM_CH; ch++) begin
                r_t_a[ch]    <= col_a[ch*pwlcr_pkg::CH_W +: pwlcr_pkg::CH_W];
                r_t_diff[ch] <= signed'({1'b0, col_b[ch*pwlcr_pkg::CH_W +: pwlcr_pkg::CH_W]})
                              - signed'({1'b0, col_a[ch*pwlcr_pkg::CH_W +: pwlcr_pkg::CH_W]});
            end
        end
    end

    // ------------------------------------------------------------------
    // stage M: t * (b - a), one 34x17 signed multiplier per channel
    // ------------------------------------------------------------------
    logic              r_m_valid;
    pwlcr_pkg::t_prod  r_m_prod [pwlcr_pkg::NUM_CH];
    pwlcr_pkg::t_chan  r_m_a    [pwlcr_pkg::NUM_CH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= r_t_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int ch = 0; ch < pwlcr_pkg::NUM_CH; ch++) begin
                r_m_prod[ch] <= r_t_t * r_t_diff[ch];
                r_m_a[ch]    <= r_t_a[ch];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage V: a + floor(prod / 2^16), clamped to [0, 65535]
    // ------------------------------------------------------------------
    logic              r_v_valid;
    pwlcr_pkg::t_color r_v_rgb;
    pwlcr_pkg::t_color n_v_rgb;
    pwlcr_pkg::t_sum   sum [pwlcr_pkg::NUM_CH];

    always_comb begin
        for (int ch = 0; ch < pwlcr_pkg::NUM_CH; ch++) begin
            sum[ch] = pwlcr_pkg::t_sum'(signed'(
                          r_m_prod[ch][pwlcr_pkg::PROD_W-1:pwlcr_pkg::FRAC_W]))
                    + pwlcr_pkg::t_sum'({1'b0, r_m_a[ch]});
            if (sum[ch][pwlcr_pkg::PROD_W-pwlcr_pkg::FRAC_W]) begin
                n_v_rgb[ch*pwlcr_pkg::CH_W +: pwlcr_pkg::CH_W] = '0;
            end else if (|sum[ch][pwlcr_pkg::PROD_W-pwlcr_pkg::FRAC_W-1:pwlcr_pkg::CH_W]) begin
                n_v_rgb[ch*pwlcr_pkg::CH_W +: pwlcr_pkg::CH_W] = '1;
            end else begin
                n_v_rgb[ch*pwlcr_pkg::CH_W +: pwlcr_pkg::CH_W] = sum[ch][pwlcr_pkg::CH_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_valid <= 1'b0;
        end else if (en) begin
            r_v_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v_rgb <= n_v_rgb;
        end
    end

    // ------------------------------------------------------------------
    // output register with skid: the stage V result lands in the output
    // register when it is free, otherwise in the skid register
    // ------------------------------------------------------------------
    logic              r_out_valid;
    pwlcr_pkg::t_color r_out_rgb;
    pwlcr_pkg::t_color r_skid_rgb;
    logic              out_free;

    assign out_free = o_out.ready || !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || r_v_valid;
            r_skid_valid <= 1'b0;
        end else if (!r_skid_valid && r_v_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_rgb <= r_skid_valid ? r_skid_rgb : r_v_rgb;
        end else if (!r_skid_valid) begin
            r_skid_rgb <= r_v_rgb;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.red   = r_out_rgb[0*pwlcr_pkg::CH_W +: pwlcr_pkg::CH_W];
    assign o_out.green = r_out_rgb[1*pwlcr_pkg::CH_W +: pwlcr_pkg::CH_W];
    assign o_out.blue  = r_out_rgb[2*pwlcr_pkg::CH_W +: pwlcr_pkg::CH_W];

endmodule

`default_nettype wire

/* sv/pwlcr_checker.sv */
// port-level checker for the color ramp, attached to the top level by bind
// depends on pwlcr_pkg, assert_macros.svh, piecewise_linear_color_ramp_top
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pwlcr_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_in_valid,
    input wire                          i_in_ready,
    input wire                          i_out_valid,
    input wire                          i_out_ready,
    input wire [pwlcr_pkg::CH_W-1:0]    i_red,
    input wire [pwlcr_pkg::CH_W-1:0]    i_green,
    input wire [pwlcr_pkg::CH_W-1:0]    i_blue
);

    logic               in_fire;
    logic               out_fire;
    pwlcr_pkg::t_flight r_in_flight;
    pwlcr_pkg::t_flight n_in_flight;

    assign in_fire  = i_in_valid && i_in_ready;
    assign out_fire = i_out_valid && i_out_ready;

    // transactions accepted and not yet delivered
    always_comb begin
        n_in_flight = r_in_flight;
        if (in_fire) begin
            n_in_flight = n_in_flight + pwlcr_pkg::t_flight'(1);
        end
        if (out_fire) begin
            n_in_flight = n_in_flight - pwlcr_pkg::t_flight'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_flight <= '0;
        end else begin
            r_in_flight <= n_in_flight;
        end
    end

    `ASSERT_ANY(a_reset_state, i_clk, !i_rst_n |=> !i_out_valid && i_in_ready,
                "reset left a result pending or input closed")
    `ASSERT_RST(a_no_extra_result, i_clk, i_rst_n, out_fire |-> r_in_flight != '0,
                "output transaction without a pending input")
    `ASSERT_RST(a_occupancy, i_clk, i_rst_n,
                r_in_flight <= pwlcr_pkg::t_flight'(pwlcr_pkg::MAX_IN_FLIGHT),
                "more transactions in flight than pipeline slots")
    `ASSERT_RST(a_out_hold, i_clk, i_rst_n,
                i_out_valid && !i_out_ready |=>
                    i_out_valid && $stable(i_red) && $stable(i_green) && $stable(i_blue),
                "stalled result changed")

endmodule

bind piecewise_linear_color_ramp_top pwlcr_checker u_pwlcr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_red       (o_out.red),
    .i_green     (o_out.green),
    .i_blue      (o_out.blue)
);

`default_nettype wire
